// File: rtl/etcp_pkg.sv
// ----------------------------------------------------------------------------
// etcp_pkg - shared constants and helpers for the Celtic escape-time pixel unit
// Fixed-point formats, register indexes and reset values, and the small
// saturation/magnitude functions used by the datapath.
// ----------------------------------------------------------------------------
package etcp_pkg;

	localparam int FRACTION_BITS  = 28;
	localparam int MAX_ITERATIONS = 100;

	// z and c parts: signed, ZW bits, FRACTION_BITS fraction bits
	localparam int ZW      = FRACTION_BITS + 4;
	localparam int REG_W   = 32;
	localparam int PIX_W   = 12;
	localparam int ZOOM_FRAC = 16;
	// quotient of |pixel| * 2^(ZOOM_FRAC + FRACTION_BITS) / zoom
	localparam int QW      = PIX_W + ZOOM_FRAC + FRACTION_BITS;
	// wide signed width used for the add/clamp steps
	localparam int EXT_W   = QW + 2;
	localparam int CMP_W   = (ZW > REG_W) ? ZW : REG_W;

	localparam int NW      = $clog2(MAX_ITERATIONS + 1);
	localparam int COUNT_W = 7;
	localparam int COLOUR_W = 32;

	// red = min(255, 255*n/100), alpha = 255 - n mod 255
	localparam int RED_SCALE      = 255;
	localparam int COLOUR_DIVISOR = 100;
	localparam int RED_WHOLE      = RED_SCALE / COLOUR_DIVISOR;
	localparam int RED_FRAC       = RED_SCALE % COLOUR_DIVISOR;
	localparam int RED_W          = 8;
	localparam int REM_W          = $clog2(COLOUR_DIVISOR);
	localparam int ALPHA_MOD      = 255;
	localparam int ALPHA_W        = 8;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ZOOM   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CIM    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BAIL   = 2'd3;

	localparam logic [REG_W-1:0] ZOOM_RESET = 32'd13107200;
	localparam logic [REG_W-1:0] CRE_RESET  = 32'd0;
	localparam logic [REG_W-1:0] CIM_RESET  = 32'd0;
	localparam logic [REG_W-1:0] BAIL_RESET = 32'd1073741824;

	localparam logic signed [EXT_W-1:0] ZMAX_X = (EXT_W'(1) <<< (ZW - 1)) - EXT_W'(1);
	localparam logic signed [EXT_W-1:0] ZMIN_X = -ZMAX_X - EXT_W'(1);

	// saturate a wide signed value into the z format
	function automatic logic signed [ZW-1:0] clamp_z(logic signed [EXT_W-1:0] v);
		logic signed [EXT_W-1:0] r;
		r = v;
		if (v > ZMAX_X)
			r = ZMAX_X;
		else if (v < ZMIN_X)
			r = ZMIN_X;
		return r[ZW-1:0];
	endfunction

	// unsigned magnitude of a z value; the most negative value maps to 2^(ZW-1)
	function automatic logic [ZW-1:0] mag_z(logic signed [ZW-1:0] v);
		return v[ZW-1] ? ZW'(-v) : ZW'(v);
	endfunction

	// floor(p / 2^F), saturated at 2^ZW - 1
	function automatic logic [ZW-1:0] sq_trunc(logic [2*ZW-1:0] p);
		logic [ZW-1:0] r;
		if (|p[2*ZW-1:ZW+FRACTION_BITS])
			r = '1;
		else
			r = p[ZW+FRACTION_BITS-1:FRACTION_BITS];
		return r;
	endfunction

	// signed quotient plus centre offset, clamped to the z range
	function automatic logic signed [ZW-1:0] map_point(logic [QW-1:0] q, logic neg,
	                                                    logic [REG_W-1:0] centre);
		logic signed [EXT_W-1:0] qs;
		logic signed [EXT_W-1:0] cs;
		qs = $signed({2'b00, q});
		if (neg)
			qs = -qs;
		cs = $signed({{(EXT_W-REG_W){centre[REG_W-1]}}, centre});
		return clamp_z(qs + cs);
	endfunction

endpackage

// File: rtl/etcp_div.sv
// ----------------------------------------------------------------------------
// etcp_div - bit-serial restoring divider for the pixel-to-point mapping
// Computes floor(dividend * 2^(QW-PIX_W) / divisor), one quotient bit a cycle.
// done pulses for one cycle with the quotient held afterwards.
// ----------------------------------------------------------------------------
module etcp_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic [etcp_pkg::PIX_W-1:0]        dividend,
	input  logic [etcp_pkg::REG_W-1:0]        divisor,
	output logic                              done,
	output logic [etcp_pkg::QW-1:0]           quotient
);

	localparam int CW = $clog2(etcp_pkg::QW);

	logic                            run_q;
	logic                            done_q;
	logic [CW-1:0]                   cnt_q;
	logic [etcp_pkg::QW-1:0]         dvd_q;
	logic [etcp_pkg::QW-1:0]         quot_q;
	logic [etcp_pkg::REG_W-1:0]      rem_q;
	logic [etcp_pkg::REG_W-1:0]      dsr_q;

	logic [etcp_pkg::REG_W:0]        trial;
	logic [etcp_pkg::REG_W:0]        trial_sub;
	logic                            fits;

	assign trial     = {rem_q, dvd_q[etcp_pkg::QW-1]};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign fits      = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(etcp_pkg::QW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so REG_W bits hold it
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q  <= {dividend, (etcp_pkg::QW - etcp_pkg::PIX_W)'(0)};
			rem_q  <= '0;
			quot_q <= '0;
			dsr_q  <= divisor;
		end else if (run_q) begin
			dvd_q  <= {dvd_q[etcp_pkg::QW-2:0], 1'b0};
			rem_q  <= fits ? trial_sub[etcp_pkg::REG_W-1:0] : trial[etcp_pkg::REG_W-1:0];
			quot_q <= {quot_q[etcp_pkg::QW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// File: rtl/escape_time_celtic_pixel.sv
// ----------------------------------------------------------------------------
// escape_time_celtic_pixel - Celtic Mandelbrot escape-time pixel unit
// Maps a pixel offset to a point c and counts Celtic iterations until escape.
// ----------------------------------------------------------------------------
// Usage:
//   A request (pixel_x, pixel_y) is taken on a clock edge with start high and
//   busy low. busy stays high until the result is out. The result appears on
//   iteration_count and pixel_colour for exactly one cycle with done high;
//   the receiver has no way to hold it, so it must sample that cycle.
//   Configuration: cfg_write with cfg_index/cfg_data writes zoom (0), centre
//   real (1), centre imag (2) and bailout (3); write only while idle.
// Sequence:
//   Two serial divides map x and y, then each iteration steps through the
//   states MULP, UPD, MULR, MULI and CHK on the single 32x32 multiplier
//   (cross product, update, re^2, im^2, check); the number of iterations
//   run is min(count + 1, 100).
//   busy drops in the done cycle, so the next request can start right away.
// Reset: asynchronous, clears config to defaults and returns to idle.
// ----------------------------------------------------------------------------
module escape_time_celtic_pixel (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [etcp_pkg::PIX_W-1:0]    pixel_x,
	input  logic signed [etcp_pkg::PIX_W-1:0]    pixel_y,
	input  logic                                 cfg_write,
	input  logic [etcp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [etcp_pkg::REG_W-1:0]           cfg_data,
	output logic                                 done,
	output logic [etcp_pkg::COUNT_W-1:0]         iteration_count,
	output logic [etcp_pkg::COLOUR_W-1:0]        pixel_colour
);

	localparam int ZW = etcp_pkg::ZW;
	localparam int EXT_W = etcp_pkg::EXT_W;
	localparam int NW = etcp_pkg::NW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIVX = 3'd1;
	localparam logic [2:0] S_DIVY = 3'd2;
	localparam logic [2:0] S_MULP = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;
	localparam logic [2:0] S_MULR = 3'd5;
	localparam logic [2:0] S_MULI = 3'd6;
	localparam logic [2:0] S_CHK  = 3'd7;

	logic [2:0]                     state_q;

	logic [etcp_pkg::REG_W-1:0]     zoom_q;
	logic [etcp_pkg::REG_W-1:0]     cre_cfg_q;
	logic [etcp_pkg::REG_W-1:0]     cim_cfg_q;
	logic [etcp_pkg::REG_W-1:0]     bail_q;

	logic                           xneg_q;
	logic signed [etcp_pkg::PIX_W-1:0] py_q;

	logic signed [ZW-1:0]           cre_q;
	logic signed [ZW-1:0]           cim_q;
	logic signed [ZW-1:0]           re_q;
	logic signed [ZW-1:0]           im_q;
	logic [ZW-1:0]                  re2_q;
	logic [ZW-1:0]                  im2_q;
	logic [2*ZW-1:0]                prod_q;

	logic [NW-1:0]                  n_q;
	logic [etcp_pkg::RED_W-1:0]     red_q;
	logic [etcp_pkg::REM_W-1:0]     rrem_q;
	logic [etcp_pkg::ALPHA_W-1:0]   amod_q;

	logic                           done_q;
	logic [etcp_pkg::COUNT_W-1:0]   count_q;
	logic [etcp_pkg::COLOUR_W-1:0]  colour_q;

	// divider hookup
	logic                           div_go;
	logic [etcp_pkg::PIX_W-1:0]     div_dvd;
	logic [etcp_pkg::REG_W-1:0]     div_dsr;
	logic                           div_done;
	logic [etcp_pkg::QW-1:0]        div_quot;

	logic                           accept;
	logic [etcp_pkg::PIX_W-1:0]     px_mag;
	logic [etcp_pkg::PIX_W-1:0]     py_mag;

	// shared multiplier
	logic [ZW-1:0]                  mul_a;
	logic [ZW-1:0]                  mul_b;
	logic [ZW-1:0]                  sq;

	// z update
	logic signed [ZW:0]             diff;
	logic [ZW-1:0]                  absd;
	logic [EXT_W-1:0]               cross_x;
	logic signed [EXT_W-1:0]        cross_term;
	logic signed [ZW-1:0]           nre;
	logic signed [ZW-1:0]           nim;

	// escape check
	logic [ZW:0]                    sum;
	logic [ZW-1:0]                  sum_sat;
	logic                           escape;

	// counters
	logic [NW-1:0]                  n_nxt;
	logic                           last;
	logic [etcp_pkg::REM_W:0]       rsum;
	logic                           rcarry;
	logic [etcp_pkg::REM_W-1:0]     rrem_nxt;
	logic [etcp_pkg::RED_W+1:0]     red_sum;
	logic [etcp_pkg::RED_W-1:0]     red_nxt;
	logic [etcp_pkg::ALPHA_W-1:0]   amod_nxt;
	logic [NW-1:0]                  n_fin;
	logic [etcp_pkg::RED_W-1:0]     red_fin;
	logic [etcp_pkg::ALPHA_W-1:0]   amod_fin;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	assign px_mag = pixel_x[etcp_pkg::PIX_W-1] ? etcp_pkg::PIX_W'(-pixel_x) : pixel_x;
	assign py_mag = py_q[etcp_pkg::PIX_W-1] ? etcp_pkg::PIX_W'(-py_q) : py_q;

	assign div_go  = accept || ((state_q == S_DIVX) && div_done);
	assign div_dvd = accept ? px_mag : py_mag;
	assign div_dsr = (zoom_q == '0) ? etcp_pkg::REG_W'(1) : zoom_q;

	etcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q    <= etcp_pkg::ZOOM_RESET;
			cre_cfg_q <= etcp_pkg::CRE_RESET;
			cim_cfg_q <= etcp_pkg::CIM_RESET;
			bail_q    <= etcp_pkg::BAIL_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				etcp_pkg::CFG_ZOOM: zoom_q    <= cfg_data;
				etcp_pkg::CFG_CRE:  cre_cfg_q <= cfg_data;
				etcp_pkg::CFG_CIM:  cim_cfg_q <= cfg_data;
				etcp_pkg::CFG_BAIL: bail_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = etcp_pkg::mag_z(re_q);
		mul_b = etcp_pkg::mag_z(im_q);
		case (state_q)
			S_MULR:  mul_b = etcp_pkg::mag_z(re_q);
			S_MULI:  mul_a = etcp_pkg::mag_z(im_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign sq = etcp_pkg::sq_trunc(prod_q);

	// new z from old z: re' = |re2 - im2| + cre, im' = -2*re*im + cim
	assign diff = $signed({1'b0, re2_q}) - $signed({1'b0, im2_q});
	assign absd = diff[ZW] ? ZW'(-diff) : ZW'(diff);
	assign nre  = etcp_pkg::clamp_z($signed({{(EXT_W-ZW){1'b0}}, absd})
	                                + $signed({{(EXT_W-ZW){cre_q[ZW-1]}}, cre_q}));

	assign cross_x    = {{(EXT_W-ZW-1){1'b0}}, sq, 1'b0};
	assign cross_term = (re_q[ZW-1] == im_q[ZW-1]) ? -$signed(cross_x) : $signed(cross_x);
	assign nim = etcp_pkg::clamp_z(cross_term
	                               + $signed({{(EXT_W-ZW){cim_q[ZW-1]}}, cim_q}));

	// |z|^2 in the check cycle: re2_q already holds the new re^2, sq the new im^2
	assign sum     = {1'b0, re2_q} + {1'b0, sq};
	assign sum_sat = sum[ZW] ? '1 : sum[ZW-1:0];
	assign escape  = etcp_pkg::CMP_W'(sum_sat) >= etcp_pkg::CMP_W'(bail_q);

	assign n_nxt = n_q + NW'(1);
	assign last  = (n_nxt == NW'(etcp_pkg::MAX_ITERATIONS));

	// running 255*n/100 as quotient and remainder
	assign rsum     = (etcp_pkg::REM_W+1)'(rrem_q) + (etcp_pkg::REM_W+1)'(etcp_pkg::RED_FRAC);
	assign rcarry   = rsum >= (etcp_pkg::REM_W+1)'(etcp_pkg::COLOUR_DIVISOR);
	assign rrem_nxt = rcarry ? etcp_pkg::REM_W'(rsum - (etcp_pkg::REM_W+1)'(etcp_pkg::COLOUR_DIVISOR))
	                         : etcp_pkg::REM_W'(rsum);
	assign red_sum  = (etcp_pkg::RED_W+2)'(red_q) + (etcp_pkg::RED_W+2)'(etcp_pkg::RED_WHOLE)
	                  + (etcp_pkg::RED_W+2)'(rcarry);
	assign red_nxt  = (red_sum > (etcp_pkg::RED_W+2)'(etcp_pkg::RED_SCALE))
	                  ? etcp_pkg::RED_W'(etcp_pkg::RED_SCALE) : etcp_pkg::RED_W'(red_sum);
	assign amod_nxt = (amod_q == etcp_pkg::ALPHA_W'(etcp_pkg::ALPHA_MOD - 1))
	                  ? '0 : amod_q + etcp_pkg::ALPHA_W'(1);

	// an escaping iteration is not counted
	assign n_fin    = escape ? n_q : n_nxt;
	assign red_fin  = escape ? red_q : red_nxt;
	assign amod_fin = escape ? amod_q : amod_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_DIVX;
				S_DIVX: if (div_done) state_q <= S_DIVY;
				S_DIVY: if (div_done) state_q <= S_MULP;
				S_MULP: state_q <= S_UPD;
				S_UPD:  state_q <= S_MULR;
				S_MULR: state_q <= S_MULI;
				S_MULI: state_q <= S_CHK;
				S_CHK: begin
					if (escape || last) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_MULP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xneg_q <= pixel_x[etcp_pkg::PIX_W-1];
			py_q   <= pixel_y;
		end
		if ((state_q == S_DIVX) && div_done)
			cre_q <= etcp_pkg::map_point(div_quot, xneg_q, cre_cfg_q);
		if ((state_q == S_DIVY) && div_done) begin
			cim_q  <= etcp_pkg::map_point(div_quot, py_q[etcp_pkg::PIX_W-1], cim_cfg_q);
			re_q   <= '0;
			im_q   <= '0;
			re2_q  <= '0;
			im2_q  <= '0;
			n_q    <= '0;
			red_q  <= '0;
			rrem_q <= '0;
			amod_q <= '0;
		end
		if (state_q == S_UPD) begin
			re_q <= nre;
			im_q <= nim;
		end
		if (state_q == S_MULI)
			re2_q <= sq;
		if (state_q == S_CHK) begin
			im2_q  <= sq;
			n_q    <= n_nxt;
			red_q  <= red_nxt;
			rrem_q <= rrem_nxt;
			amod_q <= amod_nxt;
			if (escape || last) begin
				count_q  <= etcp_pkg::COUNT_W'(n_fin);
				colour_q <= {red_fin, 16'h0000,
				             etcp_pkg::ALPHA_W'(etcp_pkg::ALPHA_MOD) - amod_fin};
			end
		end
	end

	assign done            = done_q;
	assign iteration_count = count_q;
	assign pixel_colour    = colour_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a request in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted request did not raise busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MULP) |-> (n_q < NW'(etcp_pkg::MAX_ITERATIONS)))
		else $error("iteration counter past cap");

	a_red_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MULP) |-> (rrem_q < etcp_pkg::REM_W'(etcp_pkg::COLOUR_DIVISOR)))
		else $error("red remainder out of range");

	a_div_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIVX || state_q == S_DIVY))
		else $error("divider finished outside mapping");
`endif

endmodule

// File: tb/sv/escape_time_celtic_pixel_tb.sv
// ----------------------------------------------------------------------------
// escape_time_celtic_pixel_tb - self-checking bench for the Celtic pixel unit
// Sends pixel requests through the start/busy handshake and checks every
// done strobe against a table entry or an in-bench escape-time predictor. It
// starts with a directed table (reset values, saturated points, zero zoom,
// zero and saturated bailout, extreme centres), then runs random register
// settings with mostly aimed pixels, random sender gaps and drain pauses.
// ----------------------------------------------------------------------------
module escape_time_celtic_pixel_tb;

	import etcp_pkg::*;

	typedef longint unsigned wide_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [COLOUR_W-1:0] colour;
	} pixel_result_t;

	typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [REG_W-1:0]      data;
		int                    px;
		int                    py;
		bit                    known;
		logic [COUNT_W-1:0]    count;
		logic [COLOUR_W-1:0]   colour;
	} directed_row_t;

	localparam longint Z_HI        = (longint'(1) << (ZW - 1)) - 1;
	localparam longint Z_LO        = -Z_HI - 1;
	localparam wide_t  SQ_SAT      = (wide_t'(1) << ZW) - 1;
	localparam int     QUIET_LIMIT = 3000;
	localparam int     N_PHASES    = 10;
	localparam int     PHASE_ITEMS = 73;
	localparam int     N_ROWS      = 33;

	localparam logic [COLOUR_W-1:0] COL_CAP  = 32'hFF00009B;
	localparam logic [COLOUR_W-1:0] COL_ZERO = 32'h000000FF;

	// rows with known = 0 go through the predictor
	localparam directed_row_t PLAN [N_ROWS] = '{
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          0,     0,     1'b1, 7'd100, COL_CAP},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          2047,  2047,  1'b1, 7'd0,   COL_ZERO},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          -2048, -2048, 1'b1, 7'd0,   COL_ZERO},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          -2048, 2047,  1'b1, 7'd0,   COL_ZERO},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          -150,  0,     1'b0, 7'd0,   32'd0},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          100,   -60,   1'b0, 7'd0,   32'd0},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          -300,  50,    1'b0, 7'd0,   32'd0},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          40,    120,   1'b0, 7'd0,   32'd0},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          1,     -1,    1'b0, 7'd0,   32'd0},
		// zoom of zero acts as one
		'{ROW_WRITE, CFG_ZOOM, 32'd0,          0,     0,     1'b0, 7'd0,   32'd0},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          1,     0,     1'b1, 7'd0,   COL_ZERO},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          0,     0,     1'b1, 7'd100, COL_CAP},
		// zero bailout: escapes on the first iteration
		'{ROW_WRITE, CFG_BAIL, 32'd0,          0,     0,     1'b0, 7'd0,   32'd0},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          0,     0,     1'b1, 7'd0,   COL_ZERO},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          -1,    -1,    1'b1, 7'd0,   COL_ZERO},
		'{ROW_WRITE, CFG_BAIL, 32'hFFFFFFFF,   0,     0,     1'b0, 7'd0,   32'd0},
		'{ROW_WRITE, CFG_ZOOM, 32'hFFFFFFFF,   0,     0,     1'b0, 7'd0,   32'd0},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          0,     0,     1'b1, 7'd100, COL_CAP},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          2047,  -2048, 1'b0, 7'd0,   32'd0},
		// saturated |z|^2 still reaches the largest bailout
		'{ROW_WRITE, CFG_ZOOM, 32'd1,          0,     0,     1'b0, 7'd0,   32'd0},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          -2048, 2047,  1'b1, 7'd0,   COL_ZERO},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          1,     1,     1'b1, 7'd0,   COL_ZERO},
		'{ROW_WRITE, CFG_CRE,  32'h80000000,   0,     0,     1'b0, 7'd0,   32'd0},
		'{ROW_WRITE, CFG_CIM,  32'h7FFFFFFF,   0,     0,     1'b0, 7'd0,   32'd0},
		'{ROW_WRITE, CFG_ZOOM, ZOOM_RESET,     0,     0,     1'b0, 7'd0,   32'd0},
		'{ROW_WRITE, CFG_BAIL, BAIL_RESET,     0,     0,     1'b0, 7'd0,   32'd0},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          0,     0,     1'b1, 7'd0,   COL_ZERO},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          -2048, 2047,  1'b1, 7'd0,   COL_ZERO},
		'{ROW_WRITE, CFG_CRE,  32'hF8000000,   0,     0,     1'b0, 7'd0,   32'd0},
		'{ROW_WRITE, CFG_CIM,  32'h04000000,   0,     0,     1'b0, 7'd0,   32'd0},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          0,     0,     1'b0, 7'd0,   32'd0},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          -60,   30,    1'b0, 7'd0,   32'd0},
		'{ROW_PIXEL, CFG_ZOOM, 32'd0,          2047,  0,     1'b0, 7'd0,   32'd0}
	};

	logic                    clk;
	logic                    arst_n    = 1'b0;
	logic                    start     = 1'b0;
	logic                    busy;
	logic signed [PIX_W-1:0] pixel_x   = '0;
	logic signed [PIX_W-1:0] pixel_y   = '0;
	logic                    cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [REG_W-1:0]        cfg_data  = '0;
	logic                    done;
	logic [COUNT_W-1:0]      iteration_count;
	logic [COLOUR_W-1:0]     pixel_colour;

	// bench copy of the registers
	logic [REG_W-1:0] zoom_q   = ZOOM_RESET;
	logic [REG_W-1:0] centre_re = CRE_RESET;
	logic [REG_W-1:0] centre_im = CIM_RESET;
	logic [REG_W-1:0] bail_q   = BAIL_RESET;

	pixel_result_t pending_pixels [$];

	int  mismatches = 0;
	int  n_sent     = 0;
	int  n_checked  = 0;
	int  n_capped   = 0;
	int  n_first    = 0;
	int  quiet      = 0;
	bit  burst      = 1'b0;

	escape_time_celtic_pixel i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.iteration_count (iteration_count),
		.pixel_colour    (pixel_colour)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint clip_z(longint v);
		if (v > Z_HI)
			return Z_HI;
		if (v < Z_LO)
			return Z_LO;
		return v;
	endfunction

	function automatic wide_t abs_z(longint v);
		return (v < 0) ? wide_t'(-v) : wide_t'(v);
	endfunction

	// floor(a*b / 2^F), saturated; both operands are at most 2^(ZW-1)
	function automatic wide_t fix_mul(wide_t a, wide_t b);
		wide_t p;
		p = (a * b) >> FRACTION_BITS;
		return (p > SQ_SAT) ? SQ_SAT : p;
	endfunction

	function automatic longint scale_axis(logic signed [PIX_W-1:0] pix,
	                                      logic [REG_W-1:0] centre);
		longint      p;
		logic [63:0] divisor;
		logic [63:0] numer;
		logic [63:0] quo;
		longint      v;
		p = pix;
		divisor = (zoom_q == '0) ? 64'd1 : 64'(zoom_q);
		numer = 64'((p < 0) ? -p : p) << (ZOOM_FRAC + FRACTION_BITS);
		quo = numer / divisor;
		v = (p < 0) ? -longint'(quo) : longint'(quo);
		return clip_z(v + longint'($signed(centre)));
	endfunction

	function automatic pixel_result_t escape_result(logic signed [PIX_W-1:0] px,
	                                                logic signed [PIX_W-1:0] py);
		longint        cr;
		longint        ci;
		longint        zr;
		longint        zi;
		longint        diff;
		longint        twice_prod;
		longint        nr;
		longint        ni;
		wide_t         sum;
		int            n;
		int            red;
		int            alpha;
		pixel_result_t r;
		cr = scale_axis(px, centre_re);
		ci = scale_axis(py, centre_im);
		zr = 0;
		zi = 0;
		n = 0;
		while (n < MAX_ITERATIONS) begin
			diff = longint'(fix_mul(abs_z(zr), abs_z(zr))) -
			       longint'(fix_mul(abs_z(zi), abs_z(zi)));
			twice_prod = longint'(fix_mul(abs_z(zr), abs_z(zi)) << 1);
			if ((zr < 0) == (zi < 0))
				twice_prod = -twice_prod;
			// both new parts come from the old z
			nr = clip_z(((diff < 0) ? -diff : diff) + cr);
			ni = clip_z(twice_prod + ci);
			zr = nr;
			zi = ni;
			sum = fix_mul(abs_z(zr), abs_z(zr)) + fix_mul(abs_z(zi), abs_z(zi));
			if (sum > SQ_SAT)
				sum = SQ_SAT;
			if (sum >= 64'(bail_q))
				break;
			n++;
		end
		red = (RED_SCALE * n) / COLOUR_DIVISOR;
		if (red > 255)
			red = 255;
		alpha = 255 - (n % ALPHA_MOD);
		r.count = COUNT_W'(n);
		r.colour = {8'(red), 16'd0, 8'(alpha)};
		return r;
	endfunction

	// one request; returns at the edge that takes it, with start still high
	task automatic send_pixel(input logic signed [PIX_W-1:0] px,
	                          input logic signed [PIX_W-1:0] py,
	                          input bit known, input pixel_result_t typed);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		pixel_x <= px;
		pixel_y <= py;
		do @(posedge clk); while (busy);
		pending_pixels.push_back(known ? typed : escape_result(px, py));
		n_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_ZOOM: zoom_q = data;
			CFG_CRE:  centre_re = data;
			CFG_CIM:  centre_im = data;
			CFG_BAIL: bail_q = data;
			default: ;
		endcase
	endtask

	function automatic logic [REG_W-1:0] pick_centre();
		case ($urandom_range(0, 5))
			4: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF;
			5: return $urandom;
			default: return 32'(int'($urandom_range(0, 805306368)) - 402653184);
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected result: count %0d colour %h", iteration_count,
				       pixel_colour);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				n_checked++;
				if (want.count == 7'(MAX_ITERATIONS))
					n_capped++;
				if (want.count == '0)
					n_first++;
				if (iteration_count !== want.count) begin
					$error("iteration_count: expected %0d, got %0d", want.count,
					       iteration_count);
					mismatches++;
				end
				if (pixel_colour !== want.colour) begin
					$error("pixel_colour: expected %h, got %h", want.colour, pixel_colour);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with neither a request nor a result taken
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet <= 0;
		else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		logic [REG_W-1:0] zoom_pick;
		int               span;
		int               px;
		int               py;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[i]) begin
			if (PLAN[i].kind == ROW_WRITE) begin
				drain();
				write_reg(PLAN[i].idx, PLAN[i].data);
			end else
				send_pixel(12'(PLAN[i].px), 12'(PLAN[i].py), PLAN[i].known,
				           '{PLAN[i].count, PLAN[i].colour});
		end

		for (int phase = 0; phase < N_PHASES; phase++) begin
			drain();
			case (phase == 0 ? 4 : $urandom_range(0, 7))
				4: zoom_pick = ZOOM_RESET;
				5: zoom_pick = 32'hFFFFFFFF;
				6: zoom_pick = $urandom_range(0, 32'hFFFF);
				7: zoom_pick = $urandom;
				default: zoom_pick = {16'($urandom_range(50, 900)), 16'($urandom)};
			endcase
			write_reg(CFG_ZOOM, zoom_pick);
			write_reg(CFG_CRE, phase == 0 ? CRE_RESET : pick_centre());
			write_reg(CFG_CIM, phase == 0 ? CIM_RESET : pick_centre());
			case (phase == 0 ? 0 : $urandom_range(0, 5))
				4: write_reg(CFG_BAIL, $urandom);
				5: write_reg(CFG_BAIL, $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'd0);
				default: write_reg(CFG_BAIL, BAIL_RESET);
			endcase
			// aim at roughly |c - centre| <= 2.25
			span = int'(zoom_q >> ZOOM_FRAC) * 9 / 4 + 1;
			if (span > 2047)
				span = 2047;
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					burst = !burst;
				if ($urandom_range(0, 6) == 0) begin
					px = $urandom_range(0, 4095);
					py = $urandom_range(0, 4095);
				end else begin
					px = int'($urandom_range(0, 2 * span)) - span;
					py = int'($urandom_range(0, 2 * span)) - span;
				end
				if ($urandom_range(0, 59) == 0)
					drain();
				send_pixel(12'(px), 12'(py), 1'b0, '0);
			end
		end

		drain();
		repeat (700) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			$error("%0d results never arrived", pending_pixels.size());
			mismatches++;
		end
		$display("%0d pixel requests over %0d random register settings, %0d results checked",
		         n_sent, N_PHASES, n_checked);
		$display("%0d hit the iteration cap, %0d escaped on the first iteration",
		         n_capped, n_first);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
